// ===== hw/rtl/ale_pkg.sv =====
// ----------------------------------------------------------------------------
// ale_pkg: shared types and constants for the array list engine
// Holds the transaction payloads, status and operation codes, controller
// states and the command and flag bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ale_pkg;

   localparam int KIND_W = 4;
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;
   localparam int STAT_W = 3;
   localparam int FIDX_W = 6;
   localparam int LEN_W  = 7;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND = 4'd0,
      KIND_INSERT = 4'd1,
      KIND_DELETE = 4'd2,
      KIND_SEARCH = 4'd3,
      KIND_ADD    = 4'd4,
      KIND_SUB    = 4'd5,
      KIND_MUL    = 4'd6,
      KIND_DIV    = 4'd7,
      KIND_READ   = 4'd8
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_DIVZERO  = 3'd4,
      ST_EMPTY    = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_APPEND,
      S_INS_CHECK,
      S_INS_WR,
      S_DEL_CHECK,
      S_DEL_WR,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_AR_RD,
      S_AR_DIV_GO,
      S_AR_DIV_WAIT,
      S_AR_WR,
      S_RD_RD,
      S_RD_RSP
   } state_type;

   typedef enum logic [1:0] {
      IDX_ZERO,
      IDX_COUNT,
      IDX_POS
   } idx_init_type;

   typedef enum logic [1:0] {
      RA_IDX,
      RA_PREV,
      RA_NEXT
   } rd_sel_type;

   typedef enum logic [1:0] {
      WD_OPERAND,
      WD_RDATA,
      WD_ALU
   } wr_sel_type;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] operand;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic [FIDX_W-1:0]        found_index;
      logic signed [DATA_W-1:0] read_value;
      logic [LEN_W-1:0]         length;
   } rsp_type;

   typedef struct packed {
      logic         load;
      logic         idx_init;
      idx_init_type idx_sel;
      logic         idx_inc;
      logic         idx_dec;
      logic         rd_en;
      rd_sel_type   rd_sel;
      logic         wr_en;
      wr_sel_type   wr_sel;
      logic         cnt_inc;
      logic         cnt_dec;
      logic         div_start;
      logic         respond;
      status_type   rsp_status;
      logic         with_found;
      logic         with_read;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              full;
      logic              empty;
      logic              pos_ok_ins;
      logic              pos_ok;
      logic              opnd_zero;
      logic              match;
      logic              idx_at_pos;
      logic              idx_last;
      logic              div_done;
   } flags_type;

endpackage

// ===== hw/rtl/ale_divider.sv =====
// ----------------------------------------------------------------------------
// ale_divider: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, quotient
// truncated toward zero and wrapped in two's complement.
// ----------------------------------------------------------------------------
module ale_divider
   import ale_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DATA_W-1:0] dividend,
   input  logic signed [DATA_W-1:0] divisor,
   output logic                     done,
   output logic signed [DATA_W-1:0] quotient
);

   localparam int SW = $clog2(DATA_W);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [SW-1:0]     step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   trial;

   assign trial = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
         dvs_in  = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (run_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         step_in = step_ff + SW'(1);
         if (step_ff == SW'(DATA_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;

endmodule

// ===== hw/rtl/ale_datapath.sv =====
// ----------------------------------------------------------------------------
// ale_datapath: list storage and arithmetic
// Entry memory, count, walking index, transaction register, element
// arithmetic and the registered result port.
// ----------------------------------------------------------------------------
module ale_datapath
   import ale_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   input  req_type   req_data,
   input  cmd_type   cmd,
   output flags_type flags,
   output logic      rsp_strobe,
   output rsp_type   rsp_data
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   logic [DATA_W-1:0]        mem [DEPTH];
   req_type                  req_ff;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            idx_ff, idx_in;
   logic signed [DATA_W-1:0] rdata_ff;
   logic                     rsp_strobe_ff;
   rsp_type                  rsp_data_ff;

   logic [AW-1:0]            rd_addr;
   logic signed [DATA_W-1:0] alu_out;
   logic signed [DATA_W-1:0] wr_data;
   logic signed [DATA_W-1:0] quot;
   logic                     div_done;
   logic [CMPW-1:0]          pos_w, cnt_w, idx_w;

   ale_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rdata_ff),
      .divisor  (req_ff.operand),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      case (cmd.rd_sel)
         RA_IDX:  rd_addr = idx_ff;
         RA_PREV: rd_addr = idx_ff - AW'(1);
         RA_NEXT: rd_addr = idx_ff + AW'(1);
         default: rd_addr = idx_ff;
      endcase
   end

   always_comb begin
      case (kind_type'(req_ff.kind))
         KIND_ADD: alu_out = rdata_ff + req_ff.operand;
         KIND_SUB: alu_out = rdata_ff - req_ff.operand;
         KIND_MUL: alu_out = DATA_W'(rdata_ff * req_ff.operand);
         KIND_DIV: alu_out = quot;
         default:  alu_out = rdata_ff;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         WD_OPERAND: wr_data = req_ff.operand;
         WD_RDATA:   wr_data = rdata_ff;
         WD_ALU:     wr_data = alu_out;
         default:    wr_data = req_ff.operand;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
      if (cmd.wr_en) begin
         mem[idx_ff] <= wr_data;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_init) begin
         case (cmd.idx_sel)
            IDX_ZERO:  idx_in = '0;
            IDX_COUNT: idx_in = AW'(count_ff);
            IDX_POS:   idx_in = AW'(CMPW'(req_ff.position) - CMPW'(1));
            default:   idx_in = '0;
         endcase
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + AW'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.respond) begin
         rsp_data_ff.status      <= cmd.rsp_status;
         rsp_data_ff.found_index <= cmd.with_found ? FIDX_W'(idx_ff) : '0;
         rsp_data_ff.read_value  <= cmd.with_read ? rdata_ff : '0;
         rsp_data_ff.length      <= LEN_W'(count_in);
      end
   end

   assign pos_w = CMPW'(req_ff.position);
   assign cnt_w = CMPW'(count_ff);
   assign idx_w = CMPW'(idx_ff);

   always_comb begin
      flags.kind       = req_ff.kind;
      flags.full       = count_ff >= CW'(DEPTH);
      flags.empty      = count_ff == '0;
      flags.pos_ok_ins = (pos_w != '0) && (pos_w <= cnt_w + CMPW'(1));
      flags.pos_ok     = (pos_w != '0) && (pos_w <= cnt_w);
      flags.opnd_zero  = req_ff.operand == '0;
      flags.match      = rdata_ff == req_ff.operand;
      flags.idx_at_pos = (idx_w + CMPW'(1)) == pos_w;
      flags.idx_last   = (idx_w + CMPW'(1)) >= cnt_w;
      flags.div_done   = div_done;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== hw/rtl/ale_ctrl.sv =====
// ----------------------------------------------------------------------------
// ale_ctrl: operation sequencer
// Decodes each transaction, checks its limits and walks the datapath through
// the shift, scan and element arithmetic loops one entry at a time.
// ----------------------------------------------------------------------------
module ale_ctrl
   import ale_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  flags_type flags,
   output logic      busy,
   output cmd_type   cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = S_IDLE;
            case (kind_type'(flags.kind))
               KIND_APPEND: begin
                  if (!flags.full) state_in = S_APPEND;
               end
               KIND_INSERT: begin
                  if (!flags.full && flags.pos_ok_ins) state_in = S_INS_CHECK;
               end
               KIND_DELETE: begin
                  if (!flags.empty && flags.pos_ok) state_in = S_DEL_CHECK;
               end
               KIND_SEARCH: begin
                  if (!flags.empty) state_in = S_SRCH_RD;
               end
               KIND_ADD, KIND_SUB, KIND_MUL: begin
                  if (!flags.empty) state_in = S_AR_RD;
               end
               KIND_DIV: begin
                  if (!flags.opnd_zero && !flags.empty) state_in = S_AR_RD;
               end
               KIND_READ: begin
                  if (!flags.empty && flags.pos_ok) state_in = S_RD_RD;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_APPEND:    state_in = S_IDLE;
         S_INS_CHECK: state_in = flags.idx_at_pos ? S_IDLE : S_INS_WR;
         S_INS_WR:    state_in = S_INS_CHECK;
         S_DEL_CHECK: state_in = flags.idx_last ? S_IDLE : S_DEL_WR;
         S_DEL_WR:    state_in = S_DEL_CHECK;
         S_SRCH_RD:   state_in = S_SRCH_CMP;
         S_SRCH_CMP: begin
            state_in = (flags.match || flags.idx_last) ? S_IDLE : S_SRCH_RD;
         end
         S_AR_RD: begin
            state_in = (kind_type'(flags.kind) == KIND_DIV) ? S_AR_DIV_GO : S_AR_WR;
         end
         S_AR_DIV_GO: state_in = S_AR_DIV_WAIT;
         S_AR_DIV_WAIT: begin
            if (flags.div_done) state_in = S_AR_WR;
         end
         S_AR_WR:     state_in = flags.idx_last ? S_IDLE : S_AR_RD;
         S_RD_RD:     state_in = S_RD_RSP;
         S_RD_RSP:    state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.rsp_status = ST_OK;
      busy           = state_ff != S_IDLE;
      case (state_ff)
         S_IDLE: begin
            cmd.load = start;
         end
         S_DECODE: begin
            case (kind_type'(flags.kind))
               KIND_APPEND: begin
                  if (flags.full) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_FULL;
                  end else begin
                     cmd.idx_init = 1'b1;
                     cmd.idx_sel  = IDX_COUNT;
                  end
               end
               KIND_INSERT: begin
                  if (flags.full) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_FULL;
                  end else if (!flags.pos_ok_ins) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_BADPOS;
                  end else begin
                     cmd.idx_init = 1'b1;
                     cmd.idx_sel  = IDX_COUNT;
                  end
               end
               KIND_DELETE, KIND_READ: begin
                  if (flags.empty) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_EMPTY;
                  end else if (!flags.pos_ok) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_BADPOS;
                  end else begin
                     cmd.idx_init = 1'b1;
                     cmd.idx_sel  = IDX_POS;
                  end
               end
               KIND_SEARCH: begin
                  if (flags.empty) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_EMPTY;
                  end else begin
                     cmd.idx_init = 1'b1;
                     cmd.idx_sel  = IDX_ZERO;
                  end
               end
               KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
                  if (kind_type'(flags.kind) == KIND_DIV && flags.opnd_zero) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_DIVZERO;
                  end else if (flags.empty) begin
                     cmd.respond = 1'b1;
                  end else begin
                     cmd.idx_init = 1'b1;
                     cmd.idx_sel  = IDX_ZERO;
                  end
               end
               default: begin
                  cmd.respond = 1'b1;
               end
            endcase
         end
         S_APPEND: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WD_OPERAND;
            cmd.cnt_inc = 1'b1;
            cmd.respond = 1'b1;
         end
         S_INS_CHECK: begin
            if (flags.idx_at_pos) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WD_OPERAND;
               cmd.cnt_inc = 1'b1;
               cmd.respond = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_PREV;
            end
         end
         S_INS_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WD_RDATA;
            cmd.idx_dec = 1'b1;
         end
         S_DEL_CHECK: begin
            if (flags.idx_last) begin
               cmd.cnt_dec = 1'b1;
               cmd.respond = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_NEXT;
            end
         end
         S_DEL_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WD_RDATA;
            cmd.idx_inc = 1'b1;
         end
         S_SRCH_RD, S_AR_RD, S_RD_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_IDX;
         end
         S_SRCH_CMP: begin
            if (flags.match) begin
               cmd.respond    = 1'b1;
               cmd.with_found = 1'b1;
            end else if (flags.idx_last) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_NOTFOUND;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_AR_DIV_GO: begin
            cmd.div_start = 1'b1;
         end
         S_AR_DIV_WAIT: begin
            cmd.div_start = 1'b0;
         end
         S_AR_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WD_ALU;
            if (flags.idx_last) begin
               cmd.respond = 1'b1;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_RD_RSP: begin
            cmd.respond   = 1'b1;
            cmd.with_read = 1'b1;
         end
         default: begin
            cmd.load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/array_list_engine.sv =====
// from accept to result strobe: append, read and rejected items need no entry loop;
// insert and delete loop once per shifted entry, search once per entry scanned;
// add, subtract, multiply loop once per entry, divide once per entry (32-step divider)
// one transaction at a time; busy drops in the cycle the result strobe is shown
// the receiver cannot stall; synchronous reset empties the list, memory is not cleared
// ----------------------------------------------------------------------------
// array_list_engine: ordered list of signed 32-bit entries
// Append, insert, delete, search, read and whole-list arithmetic over an
// entry memory, run by a sequencer over a shared datapath.
// ----------------------------------------------------------------------------
module array_list_engine
   import ale_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   cmd_type   cmd;
   flags_type flags;

   ale_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .busy  (busy),
      .cmd   (cmd)
   );

   ale_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .flags      (flags),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // one result per transaction, never two in a row
   a_no_double_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe on consecutive cycles");

   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("result strobe right after transaction accept");

   a_write_only_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> busy)
      else $error("entry write while idle");

   a_unused_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != ST_OK)) |->
         ((rsp_data.found_index == '0) && (rsp_data.read_value == '0)))
      else $error("result fields not cleared on error status");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: regression for the array list engine
// Drives append, insert, delete, search, read and whole-list arithmetic
// transactions through the start/busy port. A local list model predicts every
// result, and each result strobe is compared field by field with the oldest
// prediction. Directed tests cover the empty list, extreme values and a full
// list. Random phases follow, each setting its sender idle rate.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ale_pkg::*;

   localparam int LIST_DEPTH   = 64;
   localparam int POS_MAX_CODE = (1 << POS_W) - 1;
   localparam int KIND_MAX_CODE = (1 << KIND_W) - 1;
   localparam logic [KIND_W-1:0] KIND_UNUSED_LO = KIND_W'(KIND_READ + 1);
   localparam logic [KIND_W-1:0] KIND_UNUSED_HI = KIND_W'(KIND_MAX_CODE);
   localparam logic [DATA_W-1:0] MAX_POS   = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] MIN_NEG   = 32'h8000_0000;
   localparam logic [DATA_W-1:0] MINUS_ONE = '1;
   localparam logic [DATA_W-1:0] SENTINEL  = 32'h1357_9bdf;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 50;
   localparam int REPORT_LIMIT = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // list model state
   logic [DATA_W-1:0] list_mem [LIST_DEPTH];
   int                list_len = 0;

   rsp_type expected_rsps [$];
   int      error_count = 0;
   int      idle_pct = 0;

   array_list_engine #(
      .DEPTH(LIST_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // apply one operation to the list model and return the result it yields
   function automatic rsp_type apply_list_op(input req_type r);
      rsp_type           o;
      int                pos;
      int                i;
      bit                hit;
      logic [DATA_W-1:0] v;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] ua;
      logic [DATA_W-1:0] ub;
      logic [DATA_W-1:0] q;
      o = '0;
      o.status = ST_OK;
      pos = int'(r.position);
      v = r.operand;
      case (r.kind)
         KIND_APPEND: begin
            if (list_len >= LIST_DEPTH) begin
               o.status = ST_FULL;
            end else begin
               list_mem[list_len] = v;
               list_len++;
            end
         end
         KIND_INSERT: begin
            if (list_len >= LIST_DEPTH) begin
               o.status = ST_FULL;
            end else if (pos < 1 || pos > list_len + 1) begin
               o.status = ST_BADPOS;
            end else begin
               for (i = list_len; i > pos - 1; i--) list_mem[i] = list_mem[i-1];
               list_mem[pos-1] = v;
               list_len++;
            end
         end
         KIND_DELETE: begin
            if (list_len == 0) begin
               o.status = ST_EMPTY;
            end else if (pos < 1 || pos > list_len) begin
               o.status = ST_BADPOS;
            end else begin
               for (i = pos - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
            end
         end
         KIND_SEARCH: begin
            if (list_len == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.status = ST_NOTFOUND;
               hit = 1'b0;
               for (i = 0; i < list_len; i++) begin
                  if (!hit && list_mem[i] == v) begin
                     hit = 1'b1;
                     o.status = ST_OK;
                     o.found_index = i[FIDX_W-1:0];
                  end
               end
            end
         end
         KIND_ADD: for (i = 0; i < list_len; i++) list_mem[i] = list_mem[i] + v;
         KIND_SUB: for (i = 0; i < list_len; i++) list_mem[i] = list_mem[i] - v;
         KIND_MUL: for (i = 0; i < list_len; i++) list_mem[i] = list_mem[i] * v;
         KIND_DIV: begin
            if (v == '0) begin
               o.status = ST_DIVZERO;
            end else begin
               // divide magnitudes, then fix the sign: truncates toward zero and
               // lets the most negative value over minus one wrap to itself
               for (i = 0; i < list_len; i++) begin
                  a = list_mem[i];
                  ua = a[DATA_W-1] ? 0 - a : a;
                  ub = v[DATA_W-1] ? 0 - v : v;
                  q = ua / ub;
                  list_mem[i] = (a[DATA_W-1] ^ v[DATA_W-1]) ? 0 - q : q;
               end
            end
         end
         KIND_READ: begin
            if (list_len == 0) begin
               o.status = ST_EMPTY;
            end else if (pos < 1 || pos > list_len) begin
               o.status = ST_BADPOS;
            end else begin
               o.read_value = list_mem[pos-1];
            end
         end
         default: ;
      endcase
      o.length = list_len[LEN_W-1:0];
      return o;
   endfunction

   task automatic idle_cycle();
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_op(input logic [KIND_W-1:0] kind, input int pos,
                          input logic [DATA_W-1:0] value);
      req_type r;
      r.kind = kind;
      r.position = pos[POS_W-1:0];
      r.operand = value;
      while ($urandom_range(0, 99) < idle_pct) idle_cycle();
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rsps.push_back(apply_list_op(r));
   endtask

   // result checker: busy and strobe are sampled before the edge updates them
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected result: status=%0d index=%0d value=%0d length=%0d",
                        rsp_data.status, rsp_data.found_index, rsp_data.read_value,
                        rsp_data.length);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data !== want) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("mismatch: expected status=%0d index=%0d value=%0d length=%0d, %s",
                           want.status, want.found_index, want.read_value, want.length,
                           $sformatf("got status=%0d index=%0d value=%0d length=%0d",
                                     rsp_data.status, rsp_data.found_index,
                                     rsp_data.read_value, rsp_data.length));
            end
         end
      end
   end

   task automatic test_empty_list();
      idle_pct = 0;
      send_op(KIND_DELETE, 1, '0);
      send_op(KIND_READ, 1, '0);
      send_op(KIND_SEARCH, 0, '0);
      send_op(KIND_ADD, 0, 32'd5);
      send_op(KIND_DIV, 0, '0);
      send_op(KIND_UNUSED_LO, 1, MINUS_ONE);
      send_op(KIND_UNUSED_HI, POS_MAX_CODE, MAX_POS);
      send_op(KIND_INSERT, 2, 32'd9);
      send_op(KIND_INSERT, 1, 32'd9);
   endtask

   task automatic test_edge_values();
      idle_pct = 0;
      send_op(KIND_APPEND, 0, MAX_POS);
      send_op(KIND_APPEND, POS_MAX_CODE, MIN_NEG);
      send_op(KIND_APPEND, 0, MINUS_ONE);
      send_op(KIND_APPEND, 0, '0);
      send_op(KIND_INSERT, 1, 32'd5);
      send_op(KIND_INSERT, list_len + 1, -32'sd7);
      send_op(KIND_INSERT, 3, 32'd42);
      send_op(KIND_INSERT, 0, 32'd1);
      send_op(KIND_INSERT, POS_MAX_CODE, 32'd1);
      send_op(KIND_READ, 1, '0);
      send_op(KIND_READ, list_len, '0);
      send_op(KIND_READ, 0, '0);
      send_op(KIND_READ, list_len + 1, '0);
      send_op(KIND_SEARCH, 0, 32'd42);
      send_op(KIND_SEARCH, 0, 32'd12345);
      send_op(KIND_DELETE, 1, '0);
      send_op(KIND_DELETE, list_len, '0);
      send_op(KIND_DELETE, POS_MAX_CODE, '0);
      send_op(KIND_ADD, 0, 32'd1);
      send_op(KIND_SUB, 0, MIN_NEG);
      send_op(KIND_MUL, 0, MINUS_ONE);
      send_op(KIND_APPEND, 0, MIN_NEG);
      send_op(KIND_DIV, 0, MINUS_ONE);
      send_op(KIND_DIV, 0, -32'sd3);
      send_op(KIND_READ, list_len, '0);
   endtask

   task automatic test_full_list();
      idle_pct = 0;
      while (list_len < LIST_DEPTH - 1) send_op(KIND_APPEND, 0, $urandom());
      send_op(KIND_INSERT, list_len + 1, SENTINEL);
      send_op(KIND_APPEND, 0, 32'd1);
      send_op(KIND_INSERT, 1, 32'd1);
      send_op(KIND_SEARCH, 0, SENTINEL);
      send_op(KIND_READ, LIST_DEPTH, '0);
      send_op(KIND_READ, LIST_DEPTH + 1, '0);
      send_op(KIND_DIV, 0, MINUS_ONE);
      send_op(KIND_ADD, 0, MAX_POS);
      send_op(KIND_DELETE, LIST_DEPTH, '0);
      // longest shift: every entry moves up
      send_op(KIND_INSERT, 1, MIN_NEG);
      send_op(KIND_DELETE, 1, '0);
      while (list_len > 0) send_op(KIND_DELETE, $urandom_range(1, list_len), '0);
   endtask

   // each transaction waits until the previous result has come back
   task automatic test_pressure();
      idle_pct = 88;
      repeat (12) begin
         while (expected_rsps.size() != 0) idle_cycle();
         case ($urandom_range(0, 2))
            0: send_op(KIND_APPEND, 0, $urandom());
            1: send_op(KIND_READ, $urandom_range(0, list_len + 1), '0);
            default: send_op(KIND_SEARCH, 0, $urandom_range(0, 1) && list_len > 0 ?
                             list_mem[$urandom_range(0, list_len - 1)] : $urandom());
         endcase
      end
   endtask

   task automatic test_random(input int n_items, input int target_len, input int pct);
      logic [KIND_W-1:0] kind;
      logic [DATA_W-1:0] value;
      int                pick;
      int                pos;
      int                hi;
      idle_pct = pct;
      repeat (n_items) begin
         pick = $urandom_range(0, 99);
         // structural ops steer the length toward the phase target
         if (pick < 45) begin
            if (($urandom_range(0, 99) < 75) == (list_len < target_len))
               kind = $urandom_range(0, 1) ? KIND_APPEND : KIND_INSERT;
            else
               kind = KIND_DELETE;
         end else if (pick < 60) begin
            kind = KIND_SEARCH;
         end else if (pick < 75) begin
            kind = KIND_READ;
         end else if (pick < 80) begin
            kind = KIND_ADD;
         end else if (pick < 85) begin
            kind = KIND_SUB;
         end else if (pick < 90) begin
            kind = KIND_MUL;
         end else if (pick < 93) begin
            kind = KIND_DIV;
         end else begin
            kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
         end

         case ($urandom_range(0, 5))
            0, 1: value = $urandom();
            2: value = $urandom_range(0, 16) - 8;
            3: begin
               case ($urandom_range(0, 4))
                  0: value = MAX_POS;
                  1: value = MIN_NEG;
                  2: value = MINUS_ONE;
                  3: value = '0;
                  default: value = 32'd1;
               endcase
            end
            default: value = (list_len > 0) ? list_mem[$urandom_range(0, list_len - 1)]
                                            : $urandom();
         endcase

         hi = (kind == KIND_INSERT) ? list_len + 1 : list_len;
         case ($urandom_range(0, 9))
            0: pos = $urandom_range(0, POS_MAX_CODE);
            1: pos = $urandom_range(0, 1) ? hi + 1 : 0;
            default: pos = $urandom_range(1, (hi > 0) ? hi : 1);
         endcase

         // a few fully random transactions
         if (pick >= 96) begin
            kind = KIND_W'($urandom_range(0, KIND_MAX_CODE));
            pos = $urandom_range(0, POS_MAX_CODE);
            value = $urandom();
         end
         send_op(kind, pos, value);
      end
   endtask

   initial begin
      int drain;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_edge_values();
      test_full_list();
      test_pressure();
      test_random(300, 12, 0);
      test_random(300, 40, 88);
      test_random(175, 64, 7);
      test_random(200, 4, 88);

      drain = 0;
      while (expected_rsps.size() != 0 && drain < DRAIN_LIMIT) begin
         idle_cycle();
         drain++;
      end
      repeat (TAIL_CYCLES) idle_cycle();
      error_count += expected_rsps.size();

      if (error_count == 0) begin
         $display("array_list_engine regression: pass");
      end else begin
         $display("array_list_engine regression: fail");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("array_list_engine regression: fail");
      $finish;
   end

endmodule
